// ----- rtl/core/dff_pkg.sv -----
// ----------------------------------------------------------------------------
// dff_pkg
// Shared types and constants of the decimal field formatter: character
// codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package dff_pkg;

	// default parameter values
	localparam int DFF_MAX_DIGITS = 10;
	localparam int DFF_LINE_WIDTH = 20;

	// fixed field geometry
	localparam int DIGIT_LIMIT = 10;
	localparam int BCD_DIGITS  = 10;
	localparam int CONV_BITS   = 32;

	// ascii codes
	localparam logic [7:0] CHR_ZERO     = 8'h30;
	localparam logic [7:0] CHR_DOT      = 8'h2E;
	localparam logic [7:0] CHR_MINUS    = 8'h2D;
	localparam logic [7:0] CHR_QUESTION = 8'h3F;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_DOT,
		ST_FRAC,
		ST_INT,
		ST_MINUS
	} state_t;

	// what kind of character the datapath writes
	typedef enum logic [1:0] {
		KIND_DOT,
		KIND_FRAC,
		KIND_INT,
		KIND_MINUS
	} char_kind_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       conv_step;
		logic       emit;
		char_kind_t kind;
		logic       last;
	} dff_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic conv_done;
		logic frac_nz;
		logic int_nz;
		logic frac_last;
		logic int_first;
		logic int_last;
		logic int_end;
		logic minus_en;
		logic out_free;
	} dff_sts_t;

endpackage

// ----- rtl/core/dff_ctrl.sv -----
// ----------------------------------------------------------------------------
// dff_ctrl
// Sequencer of the formatter: conversion, then dot, fraction digits,
// integer digits and the minus sign, one character write per step.
// ----------------------------------------------------------------------------
module dff_ctrl
	import dff_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dff_sts_t sts,
	output dff_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (sts.conv_done) begin
					if (sts.frac_nz)     state_d = ST_DOT;
					else if (sts.int_nz) state_d = ST_INT;
					else                 state_d = ST_IDLE;
				end
			end
			ST_DOT: begin
				if (sts.out_free) state_d = ST_FRAC;
			end
			ST_FRAC: begin
				if (sts.out_free && sts.frac_last) begin
					state_d = sts.int_nz ? ST_INT : ST_IDLE;
				end
			end
			ST_INT: begin
				if (sts.out_free) begin
					if (sts.int_first && sts.minus_en) state_d = ST_MINUS;
					else if (sts.int_last)             state_d = ST_IDLE;
				end
			end
			ST_MINUS: begin
				if (sts.out_free) state_d = sts.int_end ? ST_IDLE : ST_INT;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.conv_step = 1'b0;
		cmd.emit      = 1'b0;
		cmd.kind      = KIND_DOT;
		cmd.last      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
			end
			ST_DOT: begin
				cmd.emit = sts.out_free;
				cmd.kind = KIND_DOT;
			end
			ST_FRAC: begin
				cmd.emit = sts.out_free;
				cmd.kind = KIND_FRAC;
				cmd.last = sts.frac_last && !sts.int_nz;
			end
			ST_INT: begin
				cmd.emit = sts.out_free;
				cmd.kind = KIND_INT;
				cmd.last = sts.int_last && !(sts.int_first && sts.minus_en);
			end
			ST_MINUS: begin
				cmd.emit = sts.out_free;
				cmd.kind = KIND_MINUS;
				cmd.last = sts.int_end;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// fraction digits are only written when there are some
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FRAC |-> sts.frac_nz)
		else $error("fraction phase with no fraction digits");

	// the minus sign is only reached from the first integer digit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MINUS && $past(state_q) != ST_MINUS) |-> $past(state_q) == ST_INT)
		else $error("minus phase entered out of order");

	// conversion ends when the bit counter runs out
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CONV && sts.conv_done) |=> state_q != ST_CONV)
		else $error("conversion did not finish");

endmodule

// ----- rtl/core/dff_datapath.sv -----
// ----------------------------------------------------------------------------
// dff_datapath
// Field registers, magnitude, bit-serial binary to bcd conversion, address
// generation and the output register of the formatter.
// ----------------------------------------------------------------------------
module dff_datapath
	import dff_pkg::*;
#(
	parameter int MAX_DIGITS = DFF_MAX_DIGITS,
	parameter int LINE_WIDTH = DFF_LINE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [55:0] s_tdata,
	input  dff_cmd_t    cmd,
	output dff_sts_t    sts,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	localparam int BCD_W = 4 * BCD_DIGITS;
	localparam logic [7:0] ROW_OFS1 = 8'(2 * LINE_WIDTH);
	localparam logic [7:0] ROW_OFS2 = 8'(LINE_WIDTH);
	localparam logic [7:0] ROW_OFS3 = 8'(3 * LINE_WIDTH);
	localparam logic [4:0] MAX_J    = 5'(MAX_DIGITS);

	// input fields
	logic [31:0] raw_value;
	logic        wide_value;
	logic        is_signed;
	logic        value_valid;
	logic [3:0]  int_digits;
	logic [3:0]  frac_digits;
	logic [1:0]  row;
	logic [4:0]  column;

	assign raw_value   = s_tdata[31:0];
	assign wide_value  = s_tdata[32];
	assign is_signed   = s_tdata[33];
	assign value_valid = s_tdata[34];
	assign int_digits  = s_tdata[38:35];
	assign frac_digits = s_tdata[42:39];
	assign row         = s_tdata[44:43];
	assign column      = s_tdata[49:45];

	// working registers
	logic [31:0]    mag_q;
	logic [BCD_W-1:0] bcd_q;
	logic [4:0]     bit_cnt_q;
	logic [4:0]     j_q;
	logic [3:0]     nint_q;
	logic [3:0]     nfrac_q;
	logic [6:0]     dot_addr_q;
	logic [6:0]     end_addr_q;
	logic [6:0]     minus_addr_q;
	logic           valid_q;
	logic           minus_en_q;

	// output register
	logic           out_valid_q;
	logic [6:0]     out_addr_q;
	logic [7:0]     out_code_q;
	logic           out_last_q;

	// clamp, row base, magnitude
	logic [3:0]  nint_c;
	logic [3:0]  nfrac_c;
	logic [7:0]  base;
	logic [7:0]  start;
	logic [31:0] mag_c;
	logic        neg_c;

	always_comb begin
		nint_c  = (int_digits > 4'(DIGIT_LIMIT)) ? 4'd0 : int_digits;
		nfrac_c = (frac_digits > 4'(DIGIT_LIMIT)) ? 4'd0 : frac_digits;
		case (row)
			2'd1:    base = ROW_OFS1;
			2'd2:    base = ROW_OFS2;
			2'd3:    base = ROW_OFS3;
			default: base = 8'd0;
		endcase
		start = base + {3'd0, column};
		if (wide_value) begin
			neg_c = is_signed && raw_value[31];
			mag_c = neg_c ? (32'd0 - raw_value) : raw_value;
		end else begin
			neg_c = is_signed && raw_value[15];
			mag_c = {16'd0, neg_c ? (16'd0 - raw_value[15:0]) : raw_value[15:0]};
		end
	end

	// double dabble correction ahead of each shift
	logic [BCD_W-1:0] bcd_adj;

	always_comb begin
		for (int k = 0; k < BCD_DIGITS; k++) begin
			bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ?
				(bcd_q[4*k +: 4] + 4'd3) : bcd_q[4*k +: 4];
		end
	end

	// field and conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q        <= mag_c;
			bcd_q        <= '0;
			nint_q       <= nint_c;
			nfrac_q      <= nfrac_c;
			dot_addr_q   <= 7'(start + {4'd0, nint_c});
			end_addr_q   <= 7'(start + {4'd0, nint_c} + {4'd0, nfrac_c});
			minus_addr_q <= 7'(start - 8'd1);
			valid_q      <= value_valid;
			minus_en_q   <= value_valid && neg_c && (column != 5'd0);
		end else if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[31]};
			mag_q <= {mag_q[30:0], 1'b0};
		end else if (cmd.emit && (cmd.kind == KIND_FRAC || cmd.kind == KIND_INT)) begin
			bcd_q <= {4'd0, bcd_q[BCD_W-1:4]};
		end
	end

	// bit and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			j_q       <= '0;
		end else if (cmd.load) begin
			bit_cnt_q <= '0;
			j_q       <= '0;
		end else begin
			if (cmd.conv_step) bit_cnt_q <= bit_cnt_q + 5'd1;
			if (cmd.emit && (cmd.kind == KIND_FRAC || cmd.kind == KIND_INT)) begin
				j_q <= j_q + 5'd1;
			end
		end
	end

	// character and address for the current step
	logic [4:0] jend;
	logic [7:0] digit_code;
	logic [6:0] char_address;
	logic [7:0] char_code;

	always_comb begin
		jend = {1'b0, nfrac_q} + {1'b0, nint_q};
		if (!valid_q)           digit_code = CHR_QUESTION;
		else if (j_q < MAX_J)   digit_code = CHR_ZERO + {4'd0, bcd_q[3:0]};
		else                    digit_code = CHR_ZERO;
		case (cmd.kind)
			KIND_DOT: begin
				char_address = dot_addr_q;
				char_code    = CHR_DOT;
			end
			KIND_FRAC: begin
				char_address = end_addr_q - {2'd0, j_q};
				char_code    = digit_code;
			end
			KIND_INT: begin
				char_address = end_addr_q - 7'd1 - {2'd0, j_q};
				char_code    = digit_code;
			end
			KIND_MINUS: begin
				char_address = minus_addr_q;
				char_code    = CHR_MINUS;
			end
			default: begin
				char_address = dot_addr_q;
				char_code    = CHR_DOT;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_addr_q <= char_address;
			out_code_q <= char_code;
			out_last_q <= cmd.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_code_q, out_addr_q};
	assign m_tlast  = out_last_q;

	// status
	always_comb begin
		sts.conv_done = (bit_cnt_q == 5'(CONV_BITS - 1));
		sts.frac_nz   = (nfrac_q != 4'd0);
		sts.int_nz    = (nint_q != 4'd0);
		sts.frac_last = ((j_q + 5'd1) == {1'b0, nfrac_q});
		sts.int_first = (j_q == {1'b0, nfrac_q});
		sts.int_last  = ((j_q + 5'd1) == jend);
		sts.int_end   = (j_q == jend);
		sts.minus_en  = minus_en_q;
		sts.out_free  = !out_valid_q || m_tready;
	end

endmodule

// ----- rtl/core/decimal_field_formatter.sv -----
// ----------------------------------------------------------------------------
// decimal_field_formatter
// Turns one display variable into the character writes of its decimal
// field on a four-row character display buffer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one field description per transaction; m_* returns one
//   character write per transaction, m_tlast set on the final write of a
//   field. A field with no digits produces no transaction on m_*.
//   s_tready is high only while the block is idle. After acceptance the
//   value goes through a bit-serial binary to bcd converter, all 32 bits for
//   any width, then one character is written per cycle while m_* accepts, up to 22.
//   The first write is registered at m_* once the conversion is done; an
//   item takes the conversion plus its character writes, as set by the
//   converter's bit counter and the single character write port.
//   When m_tready is low the pending write holds in the output register and
//   the sequencer waits; the last write of a field may still be pending
//   while the next field is accepted.
//   Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module decimal_field_formatter
	import dff_pkg::*;
#(
	parameter int MAX_DIGITS = DFF_MAX_DIGITS,
	parameter int LINE_WIDTH = DFF_LINE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// raw_value[31:0], wide_value, is_signed, value_valid, int_digits[3:0],
	// frac_digits[3:0], row[1:0], column[4:0], zero fill
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// char_address[6:0], char_code[7:0], zero fill
	output logic [15:0] m_tdata,
	output logic        m_tlast
);

	dff_cmd_t cmd;
	dff_sts_t sts;

	// sequencer
	dff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// conversion and character datapath
	dff_datapath #(
		.MAX_DIGITS (MAX_DIGITS),
		.LINE_WIDTH (LINE_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
